FILE: design/sbx_crossover_gene_defines.svh
// Assertion macros shared by the SBX crossover checker.
`ifndef SBX_CROSSOVER_GENE_DEFINES_SVH
`define SBX_CROSSOVER_GENE_DEFINES_SVH

// Same-cycle implication, gated off during reset
`define SBXG_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sbxg: same-cycle check failed");

// Next-cycle implication, gated off during reset
`define SBXG_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("sbxg: next-cycle check failed");

`endif

FILE: design/sbxg_pkg.sv
// Shared constants, stage map and power step for the SBX crossover pipeline.
package sbxg_pkg;

  // Fixed point format
  localparam int FRAC = 16;
  localparam logic [16:0] ONE_Q = 17'h1_0000;
  localparam logic [17:0] TWO_Q = 18'h2_0000;

  // Power / root / divider geometry
  localparam int POW_N      = 21;
  localparam int DIV_STEPS  = 16;
  localparam int REC_STEPS  = 33;
  localparam int ROOT_STEPS = FRAC + 1;
  localparam int PW         = 34;
  localparam int XW         = 33;
  localparam logic [PW-1:0] POW_CAP   = 34'h2_0000_0000;
  localparam logic [33:0]   EX_LIMIT  = 34'h1_0000_0000;

  // Stage map
  localparam int S_DIV0  = 1;
  localparam int S_POW0  = S_DIV0 + DIV_STEPS;
  localparam int S_EX    = S_POW0 + POW_N;
  localparam int S_PREP  = S_EX + 1;
  localparam int S_REC0  = S_PREP + 1;
  localparam int S_ROOT0 = S_REC0 + REC_STEPS;
  localparam int S_MUL   = S_ROOT0 + ROOT_STEPS * POW_N;
  localparam int S_FIN   = S_MUL + 1;
  localparam int NST     = S_FIN;

  // One truncated Q.16 multiply of the power chain; saturates above 2^33
  function automatic logic [PW-1:0] pow_step(input logic [PW-1:0] p, input logic [16:0] t);
    logic [PW+16:0] prod;
    logic [PW:0]    r;
    prod = (PW+17)'(p) * (PW+17)'(t);
    r    = prod[PW+16:16];
    if (r > {1'b0, POW_CAP}) begin
      return POW_CAP;
    end
    return r[PW-1:0];
  endfunction

endpackage

FILE: design/sbx_crossover_gene.sv
// SBX crossover of one gene per request: fully pipelined fixed-point engine.
// The pipeline has 432 register stages, pipe_r[0] to pipe_r[431].
// Accepts one gene per cycle while the output is not stalled; each stage holds one step (divider bit, power multiply).
// The 21st root search sets the depth: 17 trial bits, each a chain of 21 multiplies.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
module sbx_crossover_gene import sbxg_pkg::*; #(
  parameter int GENE_BITS = 32,
  parameter int RAND_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // parent_a, parent_b, lower_bound, upper_bound, prior_gene, rand_select, rand_spread
  input  logic [((5*GENE_BITS+2*RAND_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                in_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  // child_gene
  output logic [((GENE_BITS+7)/8)*8-1:0] out_tdata,
  // was_crossed
  output logic                out_tuser,
  output logic                out_tlast
);

  localparam int G     = GENE_BITS;
  localparam int R     = RAND_BITS;
  localparam int DW    = G + 2;
  localparam int OUT_W = ((G+7)/8)*8;
  localparam logic [R-1:0] HALF_R = {1'b1, {(R-1){1'b0}}};

  typedef struct packed {
    logic                crossed;
    logic                last;
    logic                eqp;
    logic                mzero;
    logic                big;
    logic signed [G-1:0] prior;
    logic signed [G-1:0] lo;
    logic signed [G-1:0] hi;
    logic signed [G-1:0] x1;
    logic signed [G:0]   s;
    logic [G-1:0]        d;
    logic [DW-1:0]       den;
    logic [DW-1:0]       rem;
    logic [32:0]         q;
    logic [15:0]         u;
    logic [16:0]         t;
    logic [PW-1:0]       p;
    logic [33:0]         ex;
    logic [16:0]         w;
    logic [16:0]         rr;
    logic [XW-1:0]       x;
    logic [16:0]         y;
    logic [G:0]          tt;
    logic [G-1:0]        child;
  } st_t;

  st_t        pipe_r   [0:NST];
  st_t        pipe_nxt [1:NST];
  st_t        st0;
  logic [NST:0] vld_r;
  logic       en;

  // Global advance: frozen only while the output holds an untaken result
  assign en        = !vld_r[NST] || out_tready;
  assign in_tready = en;

  // Entry stage: order parents, distance, gap to bounds, divisor
  always_comb begin
    logic signed [G-1:0] pa, pb, x2;
    logic signed [G:0]   g1, g2, mm, dw;
    logic [G-1:0]        m;
    logic [R-1:0]        rsel, rspr;
    logic [R+15:0]       uw;
    pa   = in_tdata[G-1:0];
    pb   = in_tdata[2*G-1:G];
    rsel = in_tdata[5*G+R-1:5*G];
    rspr = in_tdata[5*G+2*R-1:5*G+R];
    st0  = '0;
    st0.lo      = in_tdata[3*G-1:2*G];
    st0.hi      = in_tdata[4*G-1:3*G];
    st0.prior   = in_tdata[5*G-1:4*G];
    st0.crossed = (rsel <= HALF_R);
    st0.last    = in_tlast;
    st0.eqp     = (pa == pb);
    st0.x1      = (pa < pb) ? pa : pb;
    x2          = (pa < pb) ? pb : pa;
    st0.s       = (G+1)'(st0.x1) + (G+1)'(x2);
    dw          = (G+1)'(x2) - (G+1)'(st0.x1);
    st0.d       = dw[G-1:0];
    g1          = (G+1)'(st0.x1) - (G+1)'(st0.lo);
    g2          = (G+1)'(st0.hi) - (G+1)'(x2);
    mm          = (g1 < g2) ? g1 : g2;
    m           = mm[G] ? '0 : mm[G-1:0];
    st0.mzero   = (m == '0);
    st0.den     = DW'(st0.d) + DW'({m, 1'b0});
    st0.rem     = DW'(st0.d);
    uw          = {rspr, 16'h0000} >> R;
    st0.u       = uw[15:0];
  end

  // Per-stage step logic
  for (genvar k = 1; k <= NST; k++) begin : g_st
    localparam int RK  = k - S_ROOT0;
    localparam int RI  = (RK < 0) ? 0 : RK % POW_N;
    localparam int RB0 = FRAC - ((RK < 0) ? 0 : RK / POW_N);
    localparam int RB  = (RB0 < 0) ? 0 : RB0;
    localparam logic [16:0] ROOT_BIT = 17'(1) << RB;
    localparam int REC_J = k - S_REC0;

    always_comb begin
      st_t                 nx;
      logic [DW:0]         r2;
      logic [17:0]         rr2;
      logic [17:0]         al;
      logic [G+16:0]       mp;
      logic signed [G+2:0] df;
      logic signed [G+2:0] cw;
      nx = pipe_r[k-1];
      if (k >= S_DIV0 && k < S_POW0) begin
        // beta inverse: one restoring quotient bit
        r2 = {nx.rem, 1'b0};
        if (r2 >= {1'b0, nx.den}) begin
          r2   = r2 - {1'b0, nx.den};
          nx.q = {nx.q[31:0], 1'b1};
        end else begin
          nx.q = {nx.q[31:0], 1'b0};
        end
        nx.rem = r2[DW-1:0];
        if (k == S_POW0 - 1) begin
          nx.t = nx.mzero ? ONE_Q : nx.q[16:0];
          nx.p = PW'(ONE_Q);
        end
      end else if (k >= S_POW0 && k < S_EX) begin
        // beta inverse to the 21st
        nx.p = pow_step(nx.p, nx.t);
      end else if (k == S_EX) begin
        // alpha times spread draw
        al    = TWO_Q - 18'(nx.p);
        nx.ex = 34'(al) * 34'(nx.u);
      end else if (k == S_PREP) begin
        // pick direct root target or reciprocal branch
        nx.big = (nx.ex > EX_LIMIT);
        nx.x   = XW'(nx.ex[33:16]);
        al     = TWO_Q - nx.ex[33:16];
        nx.w   = al[16:0];
        nx.rr  = '0;
        nx.q   = '0;
      end else if (k >= S_REC0 && k < S_ROOT0) begin
        // 2^32 / w, one quotient bit
        rr2 = {nx.rr, (REC_J == 0)};
        if (rr2 >= {1'b0, nx.w}) begin
          rr2  = rr2 - {1'b0, nx.w};
          nx.q = {nx.q[31:0], 1'b1};
        end else begin
          nx.q = {nx.q[31:0], 1'b0};
        end
        nx.rr = rr2[16:0];
        if (k == S_ROOT0 - 1) begin
          if (nx.big) begin
            nx.x = nx.q;
          end
          nx.y = '0;
        end
      end else if (k >= S_ROOT0 && k < S_MUL) begin
        // root search: trial bit, power chain, keep if not above target
        if (RI == 0) begin
          nx.t = nx.y | ROOT_BIT;
          nx.p = PW'(ONE_Q);
        end
        nx.p = pow_step(nx.p, nx.t);
        if (RI == POW_N - 1 && nx.p <= PW'(nx.x)) begin
          nx.y = nx.t;
        end
      end else if (k == S_MUL) begin
        // betaq times distance, Q.16 truncated
        mp    = (G+17)'(nx.y) * (G+17)'(nx.d);
        nx.tt = mp[G+16:16];
      end else begin
        // halve, clamp, choose
        df = (G+3)'(nx.s) - $signed({2'b00, nx.tt});
        cw = df >>> 1;
        if (nx.eqp) begin
          cw = (G+3)'(nx.x1);
        end
        if (cw < (G+3)'(nx.lo)) begin
          cw = (G+3)'(nx.lo);
        end
        if (cw > (G+3)'(nx.hi)) begin
          cw = (G+3)'(nx.hi);
        end
        nx.child = nx.crossed ? cw[G-1:0] : nx.prior;
      end
      pipe_nxt[k] = nx;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-1:0], in_tvalid};
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= st0;
      for (int k = 1; k <= NST; k++) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  assign out_tvalid = vld_r[NST];
  assign out_tdata  = OUT_W'(pipe_r[NST].child);
  assign out_tuser  = pipe_r[NST].crossed;
  assign out_tlast  = pipe_r[NST].last;

endmodule

FILE: design/sbxg_checker.sv
// Port-level checker for the SBX crossover pipeline, bound to the top level.
`include "sbx_crossover_gene_defines.svh"

module sbxg_checker #(
  parameter int OUT_W = 32
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser,
  input logic             out_tlast
);

  // Empty output slot never blocks the input side
  `SBXG_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)

  // Stalled output blocks the input side
  `SBXG_ASSERT_IMP(a_stall_blocks_input, clk, rst_n, out_tvalid && !out_tready, !in_tready)

  // Stalled result holds until taken
  `SBXG_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind sbx_crossover_gene sbxg_checker #(.OUT_W(OUT_W)) u_sbxg_checker (.*);
